// ===== hw/rtl/pts_pkg.sv =====
// Package for the periodic task scheduler: field widths, codes and the
// structs passed between the sequencer, the task store and the select unit.
// No dependencies.
`default_nettype none

package pts_pkg;

  localparam int DEF_MAX_SLOTS = 8;

  localparam int MODE_W     = 1;
  localparam int IN_SLOT_W  = 3;
  localparam int OUT_SLOT_W = 3;
  localparam int LABEL_W    = 8;
  localparam int PERIOD_W   = 16;
  localparam int WORK_W     = 16;
  localparam int TIME_W     = 32;
  localparam int KEY_W      = 32;
  localparam int TC_W       = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;

  // input item modes
  localparam logic [MODE_W-1:0] MODE_LOAD = 1'b0;
  localparam logic [MODE_W-1:0] MODE_TICK = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_POLICY     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TASK_COUNT = 1'b1;

  // policy codes
  localparam logic POLICY_RM  = 1'b0;
  localparam logic POLICY_EDF = 1'b1;

  // flips the sign bit so signed slack orders as unsigned
  localparam logic [KEY_W-1:0] SLACK_BIAS = 32'h8000_0000;

  // one task slot as read from the store
  typedef struct packed {
    logic [LABEL_W-1:0]  label;
    logic [PERIOD_W-1:0] period;
    logic [WORK_W-1:0]   budget;
    logic [TIME_W-1:0]   next_rel;
    logic [TIME_W-1:0]   deadline;
    logic [WORK_W-1:0]   remaining;
  } slot_rec_t;

  // per-field write enables of the store
  typedef struct packed {
    logic label;
    logic period;
    logic budget;
    logic next_rel;
    logic deadline;
    logic remaining;
  } field_we_t;

  // one scheduling candidate, after release
  typedef struct packed {
    logic               ready;
    logic [KEY_W-1:0]   key;
    logic [LABEL_W-1:0] label;
    logic [WORK_W-1:0]  rem;
  } cand_t;

  // current winner of the scan
  typedef struct packed {
    logic               found;
    logic [LABEL_W-1:0] label;
    logic [WORK_W-1:0]  rem;
  } sel_best_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pts_channels.sv =====
// Valid/ready channel interfaces of the scheduler: task items in, results out.
// Depends on pts_pkg.
`default_nettype none

interface pts_in_if;
  import pts_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [MODE_W-1:0]    mode;
  logic [IN_SLOT_W-1:0] slot;
  logic [LABEL_W-1:0]   task_label;
  logic [PERIOD_W-1:0]  period;
  logic [WORK_W-1:0]    exec_budget;
  logic [PERIOD_W-1:0]  first_release;

  modport source (
    output valid, mode, slot, task_label, period, exec_budget, first_release,
    input  ready
  );
  modport sink (
    input  valid, mode, slot, task_label, period, exec_budget, first_release,
    output ready
  );
endinterface

interface pts_out_if;
  import pts_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  busy_res;
  logic [OUT_SLOT_W-1:0] running_slot;
  logic [LABEL_W-1:0]    running_label;
  logic [TIME_W-1:0]     tick_time;

  modport source (
    output valid, busy_res, running_slot, running_label, tick_time,
    input  ready
  );
  modport sink (
    input  valid, busy_res, running_slot, running_label, tick_time,
    output ready
  );
endinterface

`default_nettype wire

// ===== hw/rtl/pts_task_store.sv =====
// Task slot store: one memory per field, one write port with field enables,
// one registered read port. Depends on pts_pkg.
`default_nettype none

module pts_task_store #(
  parameter int MAX_SLOTS = pts_pkg::DEF_MAX_SLOTS,
  parameter int SLOT_W    = 3
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [SLOT_W-1:0]      wr_addr,
  input  pts_pkg::field_we_t     wr_we,
  input  pts_pkg::slot_rec_t     wr_data,
  input  logic [SLOT_W-1:0]      rd_addr,
  output pts_pkg::slot_rec_t     rd_data
);
  import pts_pkg::*;

  logic [LABEL_W-1:0]  label_mem    [MAX_SLOTS];
  logic [PERIOD_W-1:0] period_mem   [MAX_SLOTS];
  logic [WORK_W-1:0]   budget_mem   [MAX_SLOTS];
  logic [TIME_W-1:0]   next_rel_mem [MAX_SLOTS];
  logic [TIME_W-1:0]   deadline_mem [MAX_SLOTS];
  logic [WORK_W-1:0]   rem_mem      [MAX_SLOTS];

  // remaining work resets to zero: the remaining field of an entry not yet written reads as zero
  logic [MAX_SLOTS-1:0] rem_vld_r;
  slot_rec_t            rd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_vld_r <= '0;
    end else if (wr_we.remaining) begin
      rem_vld_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_we.label)     label_mem[wr_addr]    <= wr_data.label;
    if (wr_we.period)    period_mem[wr_addr]   <= wr_data.period;
    if (wr_we.budget)    budget_mem[wr_addr]   <= wr_data.budget;
    if (wr_we.next_rel)  next_rel_mem[wr_addr] <= wr_data.next_rel;
    if (wr_we.deadline)  deadline_mem[wr_addr] <= wr_data.deadline;
    if (wr_we.remaining) rem_mem[wr_addr]      <= wr_data.remaining;

    rd_r.label     <= label_mem[rd_addr];
    rd_r.period    <= period_mem[rd_addr];
    rd_r.budget    <= budget_mem[rd_addr];
    rd_r.next_rel  <= next_rel_mem[rd_addr];
    rd_r.deadline  <= deadline_mem[rd_addr];
    rd_r.remaining <= rem_vld_r[rd_addr] ? rem_mem[rd_addr] : '0;
  end

  assign rd_data = rd_r;

endmodule

`default_nettype wire

// ===== hw/rtl/pts_select_unit.sv =====
// Shared comparator of the scan: keeps the best ready candidate seen so far,
// strict less-than so ties stay with the lower slot. Depends on pts_pkg.
`default_nettype none

module pts_select_unit #(
  parameter int SLOT_W = 3
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 clear,
  input  logic                 cand_vld,
  input  pts_pkg::cand_t       cand,
  input  logic [SLOT_W-1:0]    cand_slot,
  output pts_pkg::sel_best_t   best,
  output logic [SLOT_W-1:0]    best_slot
);
  import pts_pkg::*;

  logic               found_r;
  logic [KEY_W-1:0]   key_r;
  logic [LABEL_W-1:0] label_r;
  logic [WORK_W-1:0]  rem_r;
  logic [SLOT_W-1:0]  slot_r;
  logic               take;

  assign take = cand_vld && cand.ready && (!found_r || (cand.key < key_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (clear) begin
      found_r <= 1'b0;
    end else if (take) begin
      found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      key_r   <= cand.key;
      label_r <= cand.label;
      rem_r   <= cand.rem;
      slot_r  <= cand_slot;
    end
  end

  assign best.found = found_r;
  assign best.label = label_r;
  assign best.rem   = rem_r;
  assign best_slot  = slot_r;

endmodule

`default_nettype wire

// ===== hw/rtl/periodic_task_scheduler_core.sv =====
// Top level of the periodic task scheduler: sequencer, config registers,
// output register. Depends on pts_pkg, pts_channels, pts_task_store, pts_select_unit.
//
// A load transaction (mode 0) writes one task slot, and the block is ready
// again right after. A tick transaction (mode 1) runs one scan over the
// slots in use, n = min(task_count, MAX_SLOTS): each cycle one slot is read
// from the task store, released if its release time equals the current
// time, and handed to the shared comparator, which keeps the best ready slot
// by period (rate monotonic) or by signed slack to the deadline (EDF), lowest
// slot on a tie. When the scan has drained, the update state writes the
// result to the output register. The single read port of the task store,
// one slot per cycle, sets the pace of the scan.
// in_ch.ready is low during the scan. The result register decouples the
// output: a new item is taken while the last result waits, and a tick
// stalls only at its end if the previous result is still unclaimed.
// Slots that were never loaded must not lie below task_count.
`default_nettype none

module periodic_task_scheduler_core #(
  parameter int MAX_SLOTS = pts_pkg::DEF_MAX_SLOTS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  pts_in_if.sink                          in_ch,
  pts_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [pts_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pts_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import pts_pkg::*;

  localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CNT_W  = $clog2(MAX_SLOTS + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_UPDATE} state_t;

  // ---------------------------------------------------------------- config
  logic            policy_r;
  logic [TC_W-1:0] task_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r     <= POLICY_RM;
      task_count_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_POLICY:     policy_r     <= cfg_wdata[0];
        CFG_TASK_COUNT: task_count_r <= cfg_wdata[TC_W-1:0];
        default:        ;
      endcase
    end
  end

  // slots in use, saturated to the store depth
  logic [CNT_W-1:0] n_slots;
  always_comb begin
    if (32'(task_count_r) > 32'(MAX_SLOTS)) n_slots = CNT_W'(MAX_SLOTS);
    else                                    n_slots = CNT_W'(task_count_r);
  end

  // ------------------------------------------------------------- sequencer
  state_t              state_r;
  logic [CNT_W-1:0]    cnt_r;
  logic                a_vld_r;      // store read data valid this cycle
  logic [SLOT_W-1:0]   a_slot_r;
  logic                b_vld_r;      // candidate at the comparator
  cand_t               b_cand_r;
  logic [SLOT_W-1:0]   b_slot_r;
  logic [TIME_W-1:0]   time_r;

  logic                  out_vld_r;
  logic                  out_busy_r;
  logic [OUT_SLOT_W-1:0] out_slot_r;
  logic [LABEL_W-1:0]    out_label_r;
  logic [TIME_W-1:0]     out_time_r;

  logic in_acc, tick_acc, load_ok, issue, scan_done, out_free, fin;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign tick_acc    = in_acc && (in_ch.mode == MODE_TICK);
  // loads to slots beyond the store are dropped
  assign load_ok     = in_acc && (in_ch.mode == MODE_LOAD)
                       && (32'(in_ch.slot) < 32'(MAX_SLOTS));

  assign issue     = (state_r == ST_SCAN) && (cnt_r < n_slots);
  assign scan_done = (state_r == ST_SCAN) && !issue && !a_vld_r && !b_vld_r;
  assign out_free  = !out_vld_r || out_ch.ready;
  assign fin       = (state_r == ST_UPDATE) && out_free;

  // ------------------------------------------------------------ task store
  slot_rec_t         rd;
  field_we_t         wr_we;
  slot_rec_t         wr_data;
  logic [SLOT_W-1:0] wr_addr;
  sel_best_t         best;
  logic [SLOT_W-1:0] best_slot;

  pts_task_store #(
    .MAX_SLOTS (MAX_SLOTS),
    .SLOT_W    (SLOT_W)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_addr (wr_addr),
    .wr_we   (wr_we),
    .wr_data (wr_data),
    .rd_addr (cnt_r[SLOT_W-1:0]),
    .rd_data (rd)
  );

  // Release stage: a slot whose release time is now gets its work reloaded,
  // a fresh deadline and the next release time. Its slack is then exactly
  // its period, so the key needs no subtract in that case.
  logic              rel;
  logic [TIME_W-1:0] slack;
  cand_t             cand_nxt;

  always_comb begin
    rel            = (rd.next_rel == time_r);
    slack          = rel ? TIME_W'(rd.period) : (rd.deadline - time_r);
    cand_nxt.rem   = rel ? rd.budget : rd.remaining;
    cand_nxt.ready = (cand_nxt.rem != '0);
    cand_nxt.label = rd.label;
    cand_nxt.key   = (policy_r == POLICY_EDF) ? (slack ^ SLACK_BIAS)
                                               : KEY_W'(rd.period);
  end

  // single write port, shared by load, release and the final decrement
  always_comb begin
    wr_we   = '0;
    wr_addr = a_slot_r;
    wr_data = '0;
    priority if (load_ok) begin
      wr_addr           = SLOT_W'(in_ch.slot);
      wr_we.label       = 1'b1;
      wr_we.period      = 1'b1;
      wr_we.budget      = 1'b1;
      wr_we.next_rel    = 1'b1;
      wr_we.remaining   = 1'b1;
      wr_data.label     = in_ch.task_label;
      wr_data.period    = in_ch.period;
      wr_data.budget    = in_ch.exec_budget;
      wr_data.next_rel  = TIME_W'(in_ch.first_release);
      wr_data.remaining = '0;
    end else if (a_vld_r && rel) begin
      wr_addr           = a_slot_r;
      wr_we.remaining   = 1'b1;
      wr_we.deadline    = 1'b1;
      wr_we.next_rel    = 1'b1;
      wr_data.remaining = rd.budget;
      wr_data.deadline  = time_r + TIME_W'(rd.period);
      wr_data.next_rel  = rd.next_rel + TIME_W'(rd.period);
    end else if (fin && best.found) begin
      wr_addr           = best_slot;
      wr_we.remaining   = 1'b1;
      wr_data.remaining = best.rem - WORK_W'(1);
    end else begin
      // no write this cycle
      wr_we = '0;
    end
  end

  pts_select_unit #(
    .SLOT_W (SLOT_W)
  ) u_select (
    .clk       (clk),
    .rst_n     (rst_n),
    .clear     (tick_acc),
    .cand_vld  (b_vld_r),
    .cand      (b_cand_r),
    .cand_slot (b_slot_r),
    .best      (best),
    .best_slot (best_slot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cnt_r     <= '0;
      a_vld_r   <= 1'b0;
      b_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
      time_r    <= '0;
    end else begin
      a_vld_r  <= issue;
      b_vld_r  <= a_vld_r;
      b_cand_r <= cand_nxt;
      b_slot_r <= a_slot_r;
      if (issue) begin
        cnt_r    <= cnt_r + CNT_W'(1);
        a_slot_r <= cnt_r[SLOT_W-1:0];
      end
      // a new result may replace one taken in the same cycle
      if (fin) begin
        out_vld_r <= 1'b1;
      end else if (out_vld_r && out_ch.ready) begin
        out_vld_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (tick_acc) begin
            state_r <= ST_SCAN;
            cnt_r   <= '0;
          end
        end
        ST_SCAN: begin
          if (scan_done) state_r <= ST_UPDATE;
        end
        ST_UPDATE: begin
          if (fin) begin
            state_r     <= ST_IDLE;
            out_busy_r  <= best.found;
            out_slot_r  <= best.found ? OUT_SLOT_W'(best_slot) : '0;
            out_label_r <= best.found ? best.label : '0;
            out_time_r  <= time_r;
            time_r      <= time_r + TIME_W'(1);
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_ch.valid         = out_vld_r;
  assign out_ch.busy_res      = out_busy_r;
  assign out_ch.running_slot  = out_slot_r;
  assign out_ch.running_label = out_label_r;
  assign out_ch.tick_time     = out_time_r;

endmodule

`default_nettype wire

// ===== hw/rtl/pts_checker.sv =====
// Port-level checks of the scheduler core, attached by bind.
// Depends on pts_pkg and periodic_task_scheduler_core.
`default_nettype none

module pts_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic [pts_pkg::MODE_W-1:0]        in_mode,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic                              out_busy,
  input logic [pts_pkg::OUT_SLOT_W-1:0]    out_slot,
  input logic [pts_pkg::LABEL_W-1:0]       out_label
);
  import pts_pkg::*;

  // a tick transaction starts a scan, so the core cannot take another item
  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_mode == MODE_TICK)) |=> !in_ready)
    else $error("core ready right after a tick transaction");

  // a load does not hold off the next item: the core is ready again in the next cycle
  a_load_fast: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_mode == MODE_LOAD)) |=> in_ready)
    else $error("core not ready right after a load transaction");

  // an idle result reports neither slot nor label
  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_busy) |-> ((out_slot == '0) && (out_label == '0)))
    else $error("idle result carries a slot or label");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped before it was taken");

  a_rst_clear: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind periodic_task_scheduler_core pts_checker u_pts_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_mode   (in_ch.mode),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_busy  (out_ch.busy_res),
  .out_slot  (out_ch.running_slot),
  .out_label (out_ch.running_label)
);

`default_nettype wire
